// File: rtl/fqrd_pkg.sv
// shared types and codes for the fifo queue with reverse dump
// no dependencies
package fqrd_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned CountOW = 5;

  localparam logic [2:0] ACT_ENQ   = 3'd0;
  localparam logic [2:0] ACT_DEQ   = 3'd1;
  localparam logic [2:0] ACT_RHEAD = 3'd2;
  localparam logic [2:0] ACT_RTAIL = 3'd3;
  localparam logic [2:0] ACT_DUMP  = 3'd4;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]              action;
    logic signed [WordW-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [WordW-1:0] data;
    logic signed [WordW-1:0] head_word;
    logic signed [WordW-1:0] tail_word;
    logic [CountOW-1:0]      count;
    logic                    is_empty;
    logic [1:0]              status;
    logic                    last;
  } out_t;

endpackage

// File: rtl/fqrd_ram.sv
// generic ram: one write port, two read ports, registered read data
// no dependencies
module fqrd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  output logic [Width-1:0]         rdata_a_o,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// File: rtl/fifo_queue_with_reverse_dump_unit.sv
// fifo queue of signed words with a newest-first dump
// the result strobe is registered after the exec, look and fin states; busy drops as it shows
// dump of n words: n strobes, each after a store read (drd) and an output step (dout)
// the pace is set by the single store with registered reads (act, read back, report)
// reset clears pointers and count; store contents stay undefined, no clearing pass
// results are shown for one cycle each, the receiver cannot stall
module fifo_queue_with_reverse_dump_unit
  import fqrd_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  in_i,
  output logic res_strobe_o,
  output out_t res_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_EXEC = 6'b000010,
    ST_LOOK = 6'b000100,
    ST_FIN  = 6'b001000,
    ST_DRD  = 6'b010000,
    ST_DOUT = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [AW-1:0] head_q, head_d, tail_q, tail_d, idx_q, idx_d;
  logic [CW-1:0] count_q, count_d, rem_q, rem_d;
  logic          deq_ok_q, deq_ok_d;
  logic          strobe_q, strobe_d;

  logic [2:0]              act_q, act_d;
  logic signed [WordW-1:0] val_q, val_d;
  logic signed [WordW-1:0] data_q, data_d, hw_q, hw_d, tw_q, tw_d;
  logic [1:0]              status_q, status_d;
  out_t                    out_q, out_d;

  logic             we;
  logic [AW-1:0]    waddr, raddr_a, newest;
  logic [WordW-1:0] rdata_a, rdata_b;
  logic             empty;
  logic signed [WordW-1:0] hw_rd, tw_rd;

  assign empty  = (count_q == '0);
  assign newest = (tail_q == '0) ? LastIdx : tail_q - AW'(1);
  assign raddr_a = (state_q == ST_DRD) ? idx_q : head_q;
  assign waddr   = (act_q == ACT_ENQ) ? tail_q :
                   (act_q == ACT_RHEAD) ? head_q : newest;
  assign hw_rd = empty ? '0 : rdata_a;
  assign tw_rd = empty ? '0 : rdata_b;

  fqrd_ram #(
    .Width(WordW),
    .Depth(DEPTH)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (val_q),
    .raddr_a_i(raddr_a),
    .rdata_a_o(rdata_a),
    .raddr_b_i(newest),
    .rdata_b_o(rdata_b)
  );

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    tail_d   = tail_q;
    idx_d    = idx_q;
    count_d  = count_q;
    rem_d    = rem_q;
    deq_ok_d = deq_ok_q;
    strobe_d = 1'b0;
    act_d    = act_q;
    val_d    = val_q;
    data_d   = data_q;
    hw_d     = hw_q;
    tw_d     = tw_q;
    status_d = status_q;
    out_d    = out_q;
    we       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          act_d   = in_i.action;
          val_d   = in_i.value;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        status_d = STAT_OK;
        deq_ok_d = 1'b0;
        case (act_q)
          ACT_ENQ: begin
            if (count_q == CW'(DEPTH)) begin
              status_d = STAT_FULL;
            end else begin
              we      = 1'b1;
              tail_d  = (tail_q == LastIdx) ? '0 : tail_q + AW'(1);
              count_d = count_q + CW'(1);
            end
          end
          ACT_DEQ: begin
            // store read of the old head is in flight this cycle
            if (empty) begin
              status_d = STAT_EMPTY;
            end else begin
              deq_ok_d = 1'b1;
              head_d   = (head_q == LastIdx) ? '0 : head_q + AW'(1);
              count_d  = count_q - CW'(1);
            end
          end
          ACT_RHEAD, ACT_RTAIL: begin
            if (empty) begin
              status_d = STAT_EMPTY;
            end else begin
              we = 1'b1;
            end
          end
          default: begin
          end
        endcase
        state_d = ST_LOOK;
      end
      ST_LOOK: begin
        // dequeued word arrives now; head and newest reads are issued
        data_d  = deq_ok_q ? rdata_a : '0;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (act_q == ACT_DUMP && !empty) begin
          hw_d    = hw_rd;
          tw_d    = tw_rd;
          idx_d   = newest;
          rem_d   = count_q;
          state_d = ST_DRD;
        end else begin
          out_d.data      = data_q;
          out_d.head_word = hw_rd;
          out_d.tail_word = tw_rd;
          out_d.count     = CountOW'(count_q);
          out_d.is_empty  = empty;
          out_d.status    = status_q;
          out_d.last      = 1'b1;
          strobe_d        = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_DRD: begin
        state_d = ST_DOUT;
      end
      ST_DOUT: begin
        out_d.data      = rdata_a;
        out_d.head_word = hw_q;
        out_d.tail_word = tw_q;
        out_d.count     = CountOW'(count_q);
        out_d.is_empty  = 1'b0;
        out_d.status    = STAT_OK;
        out_d.last      = (rem_q == CW'(1));
        strobe_d        = 1'b1;
        idx_d           = (idx_q == '0) ? LastIdx : idx_q - AW'(1);
        rem_d           = rem_q - CW'(1);
        state_d         = (rem_q == CW'(1)) ? ST_IDLE : ST_DRD;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      idx_q    <= '0;
      rem_q    <= '0;
      deq_ok_q <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      rem_q    <= rem_d;
      deq_ok_q <= deq_ok_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    val_q    <= val_d;
    data_q   <= data_d;
    hw_q     <= hw_d;
    tw_q     <= tw_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

  assign busy         = (state_q != ST_IDLE);
  assign res_strobe_o = strobe_q;
  assign res_o        = out_q;

endmodule
